// ----- rtl/core/weekly_alarm_matcher_assert.svh -----
// Assertion macros for the checker file of the weekly alarm matcher.
// Depends on nothing; include by bare file name.
`ifndef WEEKLY_ALARM_MATCHER_ASSERT_SVH
`define WEEKLY_ALARM_MATCHER_ASSERT_SVH

// Clocked property with the active-low reset as disable.
`define WAM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition that must never hold at a clock edge outside reset.
`define WAM_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// ----- rtl/core/wam_pkg.sv -----
// Package for the weekly alarm matcher: types, codes and the weekday helper.
// Depends on nothing; used by every module of the block.
`default_nettype none

package wam_pkg;

  localparam int NumAlarmsDefault = 8;
  localparam int CfgW             = 4;
  localparam int CountW           = 8;
  localparam int IdxW             = 3;
  localparam int SundayBit        = 6;
  localparam int InDataW          = 40;
  localparam int OutDataW         = 24;
  localparam int MaskW            = 8;

  typedef enum logic [1:0] {
    KIND_TICK    = 2'd0,
    KIND_WRITE   = 2'd1,
    KIND_DISMISS = 2'd2,
    KIND_NONE    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE      = 2'd0,
    ST_RINGING   = 2'd1,
    ST_DISMISSED = 2'd2
  } status_e;

  typedef struct packed {
    logic       enable;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [6:0] days;
  } alarm_entry_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [2:0] weekday;
  } clock_time_t;

  typedef struct packed {
    status_e             status;
    logic [CountW-1:0]   count;
  } slot_upd_t;

  // Sunday (0) selects mask bit 6, days 1..6 select bit day-1, 7 matches nothing.
  function automatic logic day_hit(input logic [6:0] days, input logic [2:0] wd);
    logic hit;
    hit = 1'b0;
    unique case (wd)
      3'd0:    hit = days[SundayBit];
      3'd7:    hit = 1'b0;
      default: hit = days[wd - 3'd1];
    endcase
    return hit;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/wam_slot_unit.sv -----
// Shared slot evaluation unit: compares one alarm with the current time and
// returns its next status and the updated wake counter. Depends on wam_pkg.
`default_nettype none

module wam_slot_unit
  import wam_pkg::*;
(
  input  alarm_entry_t      entry_i,
  input  status_e           status_i,
  input  clock_time_t       now_i,
  input  logic [CountW-1:0] count_i,
  output slot_upd_t         upd_o
);

  logic hit;

  assign hit = (entry_i.hour == now_i.hour) && (entry_i.minute == now_i.minute) &&
               day_hit(entry_i.days, now_i.weekday);

  always_comb begin
    upd_o.status = status_i;
    upd_o.count  = count_i;
    if (entry_i.enable) begin
      unique case (status_i)
        ST_IDLE: begin
          if (hit) begin
            upd_o.status = ST_RINGING;
            if (count_i != {CountW{1'b1}}) upd_o.count = count_i + 1'b1;
          end
        end
        ST_RINGING, ST_DISMISSED: begin
          if (!hit) begin
            upd_o.status = ST_IDLE;
            if (count_i != '0) upd_o.count = count_i - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/weekly_alarm_matcher.sv -----
// Top level of the weekly alarm matcher: alarm table, status, wake counter
// and the slot-walking sequencer. Depends on wam_pkg and wam_slot_unit.
//
//  Channel  | Direction | Handshake                 | Payload
//  ---------+-----------+---------------------------+---------------------------------
//  s_axis   | in        | s_axis_tvalid/tready      | tuser: kind; tdata: time + entry
//  m_axis   | out       | m_axis_tvalid/tready      | tdata: mask, wake count, needed
//  cfg      | in        | cfg_wr_en (no wait)       | cfg_wr_data: alarms_in_use
//
// A tick visits N slots, where N is alarms_in_use limited to NUM_ALARMS: after
// the accepting cycle the sequencer walks one slot per cycle through the shared
// evaluation unit, then its done state loads the result register. Writes,
// dismisses, the unused kind and a tick with N of zero go from the accepting
// cycle straight to the done state.
// The input is ready only while the sequencer is idle; a result waits in the
// output register while the next item is accepted, and a second result
// stalls the sequencer until the first is taken.
// Reset clears the table, the status of every slot, the counter and the register.
`default_nettype none

module weekly_alarm_matcher
  import wam_pkg::*;
#(
  parameter int NUM_ALARMS = NumAlarmsDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Configuration: alarms_in_use.
  input  wire logic                cfg_wr_en_i,
  input  wire logic [CfgW-1:0]     cfg_wr_data_i,
  // Input items.
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // From bit 0: now_hour[4:0], now_minute[10:5], now_weekday[13:11],
  // entry_index[16:14], entry_enable[17], entry_hour[22:18],
  // entry_minute[28:23], entry_days[35:29], zero pad[39:36].
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,
  // kind[1:0].
  input  wire logic [1:0]          s_axis_tuser_i,
  // Result items.
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // From bit 0: ringing_mask[7:0], wake_count[15:8], wake_needed[16],
  // zero pad[23:17].
  output logic [OutDataW-1:0]      m_axis_tdata_o
);

  // Slot index width and a count width that can hold both the register and
  // NUM_ALARMS itself.
  localparam int AW    = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;
  localparam int NW    = $clog2(NUM_ALARMS + 1);
  localparam int CNTW  = (NW > CfgW) ? NW : CfgW;
  localparam int SHOWN = (NUM_ALARMS < MaskW) ? NUM_ALARMS : MaskW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } state_e;

  state_e             state_q;
  logic [CfgW-1:0]    in_use_q;
  alarm_entry_t       table_q  [NUM_ALARMS];
  status_e            status_q [NUM_ALARMS];
  logic [CountW-1:0]  wake_q;
  clock_time_t        now_q;
  logic [AW-1:0]      walk_q;
  logic               out_valid_q;
  logic [MaskW-1:0]   out_mask_q;
  logic [CountW-1:0]  out_count_q;

  // Unpack the input item.
  kind_e        in_kind;
  clock_time_t  in_now;
  logic [IdxW-1:0] in_idx;
  alarm_entry_t in_entry;

  assign in_kind        = kind_e'(s_axis_tuser_i);
  assign in_now.hour    = s_axis_tdata_i[4:0];
  assign in_now.minute  = s_axis_tdata_i[10:5];
  assign in_now.weekday = s_axis_tdata_i[13:11];
  assign in_idx         = s_axis_tdata_i[16:14];
  assign in_entry.enable = s_axis_tdata_i[17];
  assign in_entry.hour   = s_axis_tdata_i[22:18];
  assign in_entry.minute = s_axis_tdata_i[28:23];
  assign in_entry.days   = s_axis_tdata_i[35:29];

  logic in_fire;
  logic idx_ok;
  logic [AW-1:0] slot_sel;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign idx_ok          = (32'(in_idx) < 32'(NUM_ALARMS));

  // The status table has one read address: the requested slot while idle,
  // the walk position otherwise.
  assign slot_sel = (state_q == S_IDLE) ? AW'(in_idx) : walk_q;

  // Number of slots visited on a tick, limited to the table size.
  logic [CNTW-1:0] in_use_ext;
  logic [CNTW-1:0] walk_count;
  logic            walk_last;

  assign in_use_ext = CNTW'(in_use_q);
  assign walk_count = (in_use_ext > CNTW'(NUM_ALARMS)) ? CNTW'(NUM_ALARMS) : in_use_ext;
  assign walk_last  = ((CNTW'(walk_q) + CNTW'(1)) == walk_count);

  // Shared evaluation unit, fed from the slot under the walk pointer.
  slot_upd_t upd;

  wam_slot_unit u_slot (
    .entry_i  (table_q[walk_q]),
    .status_i (status_q[slot_sel]),
    .now_i    (now_q),
    .count_i  (wake_q),
    .upd_o    (upd)
  );

  // Ringing mask of the first slots, up to eight (MaskW).
  logic [MaskW-1:0] ring_mask;

  always_comb begin
    ring_mask = '0;
    for (int i = 0; i < SHOWN; i++) begin
      ring_mask[i] = (status_q[i] == ST_RINGING);
    end
  end

  logic out_free;
  assign out_free = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_use_q    <= '0;
      wake_q      <= '0;
      now_q       <= '0;
      walk_q      <= '0;
      out_valid_q <= 1'b0;
      out_mask_q  <= '0;
      out_count_q <= '0;
      for (int i = 0; i < NUM_ALARMS; i++) begin
        table_q[i]  <= '0;
        status_q[i] <= ST_IDLE;
      end
    end else begin
      if (cfg_wr_en_i) in_use_q <= cfg_wr_data_i;

      // A new result is loaded when the register is free; otherwise a taken
      // result leaves the register empty.
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            now_q   <= in_now;
            walk_q  <= '0;
            // Only a tick with slots in use needs the walk.
            state_q <= (in_kind == KIND_TICK && walk_count != '0) ? S_WALK : S_DONE;
            unique case (in_kind)
              KIND_WRITE: begin
                if (idx_ok) begin
                  table_q[AW'(in_idx)]  <= in_entry;
                  status_q[AW'(in_idx)] <= ST_IDLE;
                end
              end
              KIND_DISMISS: begin
                if (idx_ok && status_q[slot_sel] == ST_RINGING) begin
                  status_q[slot_sel] <= ST_DISMISSED;
                end
              end
              default: ;
            endcase
          end
        end
        S_WALK: begin
          // One slot per cycle through the shared unit.
          status_q[walk_q] <= upd.status;
          wake_q           <= upd.count;
          walk_q           <= walk_q + 1'b1;
          if (walk_last) state_q <= S_DONE;
        end
        S_DONE: begin
          // Capture the result once the output register is free.
          if (out_free) begin
            out_mask_q  <= ring_mask;
            out_count_q <= wake_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, (out_count_q != '0), out_count_q, out_mask_q};

endmodule

`default_nettype wire

// ----- rtl/core/wam_checker.sv -----
// Port-level checker for the weekly alarm matcher, bound to the top level.
// Depends on wam_pkg and the assertion macro header.
`default_nettype none
`include "weekly_alarm_matcher_assert.svh"

module wam_checker
  import wam_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                s_axis_tvalid_i,
  input wire logic                s_axis_tready_o,
  input wire logic                m_axis_tvalid_o,
  input wire logic                m_axis_tready_i,
  input wire logic [OutDataW-1:0] m_axis_tdata_o
);

  // The wake flag follows the counter field.
  `WAM_NEVER(a_needed_matches, clk_i, rst_ni, m_axis_tvalid_o && (m_axis_tdata_o[16] != (m_axis_tdata_o[15:8] != 8'd0)), "wake_needed disagrees with wake_count")

  // An accepted item occupies the sequencer in the following cycle.
  `WAM_ASSERT(a_busy_after_accept, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o, "input ready right after an accept")

  // A stalled result holds.
  `WAM_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o), "stalled result changed")

endmodule

bind weekly_alarm_matcher wam_checker u_wam_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire
